/* rtl/page_framebuffer_glyph_writer_defines.svh */
// ----------------------------------------------------------------------------
// Glyph writer assertion macros
// Shorthands for clocked implication checks, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_GLYPH_WRITER_DEFINES_SVH
`define PAGE_FRAMEBUFFER_GLYPH_WRITER_DEFINES_SVH

// Same-cycle implication.
`define PFGW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PFGW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pfgw_pkg.sv */
// ----------------------------------------------------------------------------
// Glyph writer package
// Beat types, command codes and shared constants.
// ----------------------------------------------------------------------------
package pfgw_pkg;

  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 64;
  localparam int MAX_GLYPH_ROWS    = 32;

  localparam logic [4:0] FONT_WIDTH_RST  = 5'd7;
  localparam logic [5:0] FONT_HEIGHT_RST = 6'd10;

  localparam logic [2:0] REQ_PIXEL  = 3'd0;
  localparam logic [2:0] REQ_GLYPH  = 3'd1;
  localparam logic [2:0] REQ_CURSOR = 3'd2;
  localparam logic [2:0] REQ_INVERT = 3'd3;
  localparam logic [2:0] REQ_FILL   = 3'd4;
  localparam logic [2:0] REQ_READ   = 3'd5;

  localparam logic CFG_FONT_WIDTH  = 1'b0;
  localparam logic CFG_FONT_HEIGHT = 1'b1;
  localparam int   CFG_DATA_W      = 6;

  localparam logic [15:0] GLYPH_MSB = 16'h8000;
  localparam logic [7:0]  BYTE_ONES = 8'hFF;
  localparam logic [7:0]  BYTE_ZERO = 8'h00;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic        color;
    logic [15:0] row_bits;
    logic        first_row;
    logic        last_row;
    logic [9:0]  byte_index;
  } in_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] read_data;
    logic [7:0] cursor_now;
  } out_t;

endpackage

/* rtl/pfgw_store.sv */
// ----------------------------------------------------------------------------
// Frame store
// Byte memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pfgw_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/pfgw_pixel_unit.sv */
// ----------------------------------------------------------------------------
// Pixel unit
// Shared bounds check, byte address and bit merge for one pixel.
// ----------------------------------------------------------------------------
module pfgw_pixel_unit #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int AW            = 10
) (
  input  logic [7:0]    base_x,
  input  logic [8:0]    base_y,
  input  logic [4:0]    step,
  input  logic [15:0]   bits,
  input  logic          color,
  input  logic          invert,
  input  logic [7:0]    old_byte,
  output logic          hit,
  output logic [AW-1:0] addr,
  output logic [7:0]    new_byte
);

  logic [8:0]  x;
  logic [15:0] shifted;
  logic        font_on;
  logic        pix;
  logic [7:0]  mask;

  always_comb begin
    x        = {1'b0, base_x} + {4'b0, step};
    // bits past the sixteenth column count as off
    shifted  = bits << step[3:0];
    font_on  = !step[4] && shifted[15];
    pix      = (font_on ? color : !color) ^ invert;
    hit      = (x < 9'(SCREEN_WIDTH)) && (base_y < 9'(SCREEN_HEIGHT));
    addr     = AW'(base_y[5:3]) * AW'(SCREEN_WIDTH) + AW'(x);
    mask     = 8'd1 << base_y[2:0];
    new_byte = pix ? (old_byte | mask) : (old_byte & ~mask);
  end

endmodule

/* rtl/page_framebuffer_glyph_writer.sv */
// ----------------------------------------------------------------------------
// Page framebuffer glyph writer
// Cursor, invert, unused and non-drawing glyph beats answer without going busy;
// a pixel reads and then writes its byte, a byte read reads the store, a drawn
// glyph row does one read and one write of the store port per pixel, and fill
// sweeps the whole store. One command at a time; busy stays high until done.
// Reset: a clearing pass over all STORE_BYTES bytes with busy high, no result.
// ----------------------------------------------------------------------------
`include "page_framebuffer_glyph_writer_defines.svh"

module page_framebuffer_glyph_writer #(
  parameter int SCREEN_WIDTH  = pfgw_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = pfgw_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // command side
  input  logic                              start,
  output logic                              busy,
  input  pfgw_pkg::in_t                     in_item,
  // result side
  output logic                              out_strobe,
  output pfgw_pkg::out_t                    out_item,
  // configuration
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [pfgw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import pfgw_pkg::*;

  localparam int STORE_BYTES = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);
  localparam int AW          = $clog2(STORE_BYTES);

  // sequencer codes
  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_PX_RD   = 3'd2;
  localparam logic [2:0] S_PX_WR   = 3'd3;
  localparam logic [2:0] S_RB_RD   = 3'd4;
  localparam logic [2:0] S_RB_DONE = 3'd5;

  // control state
  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic          emit_fill_r, emit_fill_nxt;
  logic [7:0]    cursor_x_r, cursor_x_nxt;
  logic [7:0]    cursor_y_r, cursor_y_nxt;
  logic          invert_r, invert_nxt;
  logic [4:0]    row_cnt_r, row_cnt_nxt;
  logic          rows_full_r, rows_full_nxt;
  logic          fits_r, fits_nxt;
  logic [4:0]    font_w_r, font_w_nxt;
  logic [5:0]    font_h_r, font_h_nxt;
  logic [4:0]    step_r, step_nxt;
  logic          out_strobe_r, out_strobe_nxt;

  // working payload
  logic [7:0]    fill_byte_r, fill_byte_nxt;
  logic [7:0]    base_x_r, base_x_nxt;
  logic [8:0]    base_y_r, base_y_nxt;
  logic [15:0]   bits_r, bits_nxt;
  logic          color_r, color_nxt;
  logic [4:0]    span_r, span_nxt;
  logic [9:0]    bidx_r, bidx_nxt;
  out_t          out_item_r, out_item_nxt;

  // store port
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // pixel unit
  logic          px_hit;
  logic [AW-1:0] px_addr;
  logic [7:0]    px_new;

  // glyph start decisions
  logic [8:0]    g_wsum;
  logic [8:0]    g_hsum;
  logic          g_fit;
  logic          g_fits;
  logic [4:0]    g_cnt;
  logic          g_full;
  logic [5:0]    g_limit;
  logic          g_rowin;

  // immediate result
  logic          emit_now;
  logic          acc_now;

  pfgw_store #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pfgw_pixel_unit #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .AW            (AW)
  ) u_pixel (
    .base_x   (base_x_r),
    .base_y   (base_y_r),
    .step     (step_r),
    .bits     (bits_r),
    .color    (color_r),
    .invert   (invert_r),
    .old_byte (mem_rdata),
    .hit      (px_hit),
    .addr     (px_addr),
    .new_byte (px_new)
  );

  // Glyph start: a first row restarts the glyph and checks the space left
  // at the cursor; otherwise the running glyph state carries on.
  always_comb begin
    g_wsum  = {1'b0, cursor_x_r} + {4'b0, font_w_r};
    g_hsum  = {1'b0, cursor_y_r} + {3'b0, font_h_r};
    g_fit   = !((g_wsum >= 9'(SCREEN_WIDTH)) || (g_hsum >= 9'(SCREEN_HEIGHT)));
    g_fits  = in_item.first_row ? g_fit : fits_r;
    g_cnt   = in_item.first_row ? 5'd0 : row_cnt_r;
    g_full  = in_item.first_row ? 1'b0 : rows_full_r;
    g_limit = (font_h_r > 6'(MAX_GLYPH_ROWS)) ? 6'(MAX_GLYPH_ROWS) : font_h_r;
    // row falls inside the glyph height and the row counter has not run out
    g_rowin = !g_full && ({1'b0, g_cnt} < g_limit);
  end

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    emit_fill_nxt = emit_fill_r;
    cursor_x_nxt  = cursor_x_r;
    cursor_y_nxt  = cursor_y_r;
    invert_nxt    = invert_r;
    row_cnt_nxt   = row_cnt_r;
    rows_full_nxt = rows_full_r;
    fits_nxt      = fits_r;
    font_w_nxt    = font_w_r;
    font_h_nxt    = font_h_r;
    step_nxt      = step_r;
    out_strobe_nxt = 1'b0;

    fill_byte_nxt = fill_byte_r;
    base_x_nxt    = base_x_r;
    base_y_nxt    = base_y_r;
    bits_nxt      = bits_r;
    color_nxt     = color_r;
    span_nxt      = span_r;
    bidx_nxt      = bidx_r;
    out_item_nxt  = out_item_r;

    mem_we    = 1'b0;
    mem_waddr = px_addr;
    mem_wdata = px_new;
    mem_raddr = px_addr;

    emit_now = 1'b0;
    acc_now  = 1'b1;

    // register writes must arrive only while idle; the block itself does not enforce it
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FONT_WIDTH:  font_w_nxt = cfg_wdata[4:0];
        CFG_FONT_HEIGHT: font_h_nxt = cfg_wdata[5:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_CLEAR: begin
        // sweep the whole store with the fill byte, one byte a cycle
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        mem_wdata = fill_byte_r;
        addr_nxt  = addr_r + AW'(1);
        if (addr_r == AW'(STORE_BYTES - 1)) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
          if (emit_fill_r) begin
            out_strobe_nxt          = 1'b1;
            out_item_nxt.accepted   = 1'b1;
            out_item_nxt.read_data  = BYTE_ZERO;
            out_item_nxt.cursor_now = cursor_x_r;
          end
          emit_fill_nxt = 1'b0;
        end
      end

      S_IDLE: begin
        if (start) begin
          case (in_item.req_type)
            REQ_PIXEL: begin
              // a single pixel is a one-column row with its font bit set
              base_x_nxt = in_item.pos_x;
              base_y_nxt = {1'b0, in_item.pos_y};
              bits_nxt   = GLYPH_MSB;
              color_nxt  = in_item.color;
              step_nxt   = '0;
              span_nxt   = 5'd1;
              state_nxt  = S_PX_RD;
            end
            REQ_GLYPH: begin
              row_cnt_nxt   = g_cnt;
              rows_full_nxt = g_full;
              fits_nxt      = g_fits;
              if (!g_fits) begin
                emit_now = 1'b1;
                acc_now  = 1'b0;
              end else begin
                if (g_rowin) begin
                  if (g_cnt == 5'(MAX_GLYPH_ROWS - 1)) begin
                    rows_full_nxt = 1'b1;
                  end else begin
                    row_cnt_nxt = g_cnt + 5'd1;
                  end
                end
                // draw from the cursor as it stands now; the last row advances it
                base_x_nxt = cursor_x_r;
                base_y_nxt = {1'b0, cursor_y_r} + {4'b0, g_cnt};
                bits_nxt   = in_item.row_bits;
                color_nxt  = in_item.color;
                step_nxt   = '0;
                span_nxt   = font_w_r;
                if (in_item.last_row) begin
                  cursor_x_nxt = cursor_x_r + {3'b0, font_w_r};
                  fits_nxt     = 1'b0;
                end
                if (g_rowin && (font_w_r != 5'd0)) begin
                  state_nxt = S_PX_RD;
                end else begin
                  emit_now = 1'b1;
                end
              end
            end
            REQ_CURSOR: begin
              cursor_x_nxt = in_item.pos_x;
              cursor_y_nxt = in_item.pos_y;
              emit_now     = 1'b1;
            end
            REQ_INVERT: begin
              invert_nxt = !invert_r;
              emit_now   = 1'b1;
            end
            REQ_FILL: begin
              fill_byte_nxt = in_item.color ? BYTE_ONES : BYTE_ZERO;
              addr_nxt      = '0;
              emit_fill_nxt = 1'b1;
              state_nxt     = S_CLEAR;
            end
            REQ_READ: begin
              bidx_nxt  = in_item.byte_index;
              state_nxt = S_RB_RD;
            end
            default: begin
              emit_now = 1'b1;
            end
          endcase
        end
      end

      S_PX_RD: begin
        // fetch the byte holding the current pixel
        mem_raddr = px_addr;
        state_nxt = S_PX_WR;
      end

      S_PX_WR: begin
        // merge the pixel bit and write back; drop pixels off the panel
        mem_we    = px_hit;
        mem_waddr = px_addr;
        mem_wdata = px_new;
        step_nxt  = step_r + 5'd1;
        if ((step_r + 5'd1) == span_r) begin
          state_nxt               = S_IDLE;
          out_strobe_nxt          = 1'b1;
          out_item_nxt.accepted   = 1'b1;
          out_item_nxt.read_data  = BYTE_ZERO;
          out_item_nxt.cursor_now = cursor_x_r;
        end else begin
          state_nxt = S_PX_RD;
        end
      end

      S_RB_RD: begin
        mem_raddr = AW'(bidx_r);
        state_nxt = S_RB_DONE;
      end

      S_RB_DONE: begin
        state_nxt               = S_IDLE;
        out_strobe_nxt          = 1'b1;
        out_item_nxt.accepted   = 1'b1;
        out_item_nxt.read_data  = (32'(bidx_r) < 32'(STORE_BYTES)) ? mem_rdata : BYTE_ZERO;
        out_item_nxt.cursor_now = cursor_x_r;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // commands that finish in the accept cycle
    if (emit_now) begin
      out_strobe_nxt          = 1'b1;
      out_item_nxt.accepted   = acc_now;
      out_item_nxt.read_data  = BYTE_ZERO;
      out_item_nxt.cursor_now = cursor_x_nxt;
    end
  end

  // control registers; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      addr_r       <= '0;
      emit_fill_r  <= 1'b0;
      cursor_x_r   <= '0;
      cursor_y_r   <= '0;
      invert_r     <= 1'b0;
      row_cnt_r    <= '0;
      rows_full_r  <= 1'b0;
      fits_r       <= 1'b0;
      font_w_r     <= FONT_WIDTH_RST;
      font_h_r     <= FONT_HEIGHT_RST;
      step_r       <= '0;
      out_strobe_r <= 1'b0;
      fill_byte_r  <= BYTE_ZERO;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      emit_fill_r  <= emit_fill_nxt;
      cursor_x_r   <= cursor_x_nxt;
      cursor_y_r   <= cursor_y_nxt;
      invert_r     <= invert_nxt;
      row_cnt_r    <= row_cnt_nxt;
      rows_full_r  <= rows_full_nxt;
      fits_r       <= fits_nxt;
      font_w_r     <= font_w_nxt;
      font_h_r     <= font_h_nxt;
      step_r       <= step_nxt;
      out_strobe_r <= out_strobe_nxt;
      fill_byte_r  <= fill_byte_nxt;
    end
  end

  // working payload, no reset needed
  always_ff @(posedge clk) begin
    base_x_r   <= base_x_nxt;
    base_y_r   <= base_y_nxt;
    bits_r     <= bits_nxt;
    color_r    <= color_nxt;
    span_r     <= span_nxt;
    bidx_r     <= bidx_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // an accepted command either keeps the block busy or answers next cycle
  `PFGW_ASSERT_NXT(a_accept_reacts, clk, rst_n, start && !busy, busy || out_strobe,
                   "accepted beat left no trace")
  // results only leave once the sequencer is back at rest
  `PFGW_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_strobe, !busy,
                   "result beat while busy")
  // a cursor set reports the new column right away
  `PFGW_ASSERT_NXT(a_cursor_set, clk, rst_n,
                   start && !busy && in_item.req_type == REQ_CURSOR,
                   out_strobe && out_item.cursor_now == $past(in_item.pos_x),
                   "cursor set not reflected")

endmodule

/* dv/glyph_writer_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Glyph writer result checker
// Mirrors the frame store, text cursor, invert flag and font registers from
// the command and configuration beats it sees, and compares every result
// beat against the oldest predicted status.
// ----------------------------------------------------------------------------
module glyph_writer_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  pfgw_pkg::in_t                   cmd,
  input  logic                            out_strobe,
  input  pfgw_pkg::out_t                  result,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [pfgw_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              outstanding,
  output int                              fail_count
);
  import pfgw_pkg::*;

  localparam int SW          = SCREEN_WIDTH_DEF;
  localparam int SH          = SCREEN_HEIGHT_DEF;
  localparam int STORE_BYTES = SW * ((SH + 7) / 8);

  logic [7:0] pixmap [STORE_BYTES];
  logic [7:0] cur_x;
  logic [7:0] cur_y;
  logic       invert_on;
  logic       glyph_ok;
  logic       rows_full;
  int         row_n;
  logic [4:0] font_w;
  logic [5:0] font_h;
  out_t       status_q [$];
  int         errs = 0;

  function automatic void plot(int x, int y, logic white);
    int idx;
    if (x >= SW || y >= SH) return;
    idx = x + (y / 8) * SW;
    if (invert_on) white = ~white;
    if (white) pixmap[idx] = pixmap[idx] | (8'd1 << (y % 8));
    else       pixmap[idx] = pixmap[idx] & ~(8'd1 << (y % 8));
  endfunction

  // Apply one command to the mirrored state and return its status beat.
  function automatic out_t predict_status(in_t c);
    out_t r;
    int   lim;
    logic lit;
    r.accepted  = 1'b1;
    r.read_data = BYTE_ZERO;
    case (c.req_type)
      REQ_PIXEL: plot(int'(c.pos_x), int'(c.pos_y), c.color);
      REQ_GLYPH: begin
        if (c.first_row) begin
          row_n     = 0;
          rows_full = 1'b0;
          glyph_ok  = !(SW <= int'(cur_x) + int'(font_w) || SH <= int'(cur_y) + int'(font_h));
        end
        if (!glyph_ok) begin
          r.accepted = 1'b0;
        end else begin
          lim = (int'(font_h) < MAX_GLYPH_ROWS) ? int'(font_h) : MAX_GLYPH_ROWS;
          if (!rows_full && row_n < lim) begin
            for (int j = 0; j < int'(font_w); j++) begin
              lit = |(c.row_bits & (GLYPH_MSB >> j));
              plot(int'(cur_x) + j, int'(cur_y) + row_n, lit ? c.color : ~c.color);
            end
            if (row_n == MAX_GLYPH_ROWS - 1) rows_full = 1'b1;
            else                             row_n++;
          end
          if (c.last_row) begin
            cur_x    = cur_x + 8'(font_w);
            glyph_ok = 1'b0;
          end
        end
      end
      REQ_CURSOR: begin
        cur_x = c.pos_x;
        cur_y = c.pos_y;
      end
      REQ_INVERT: invert_on = ~invert_on;
      REQ_FILL:   foreach (pixmap[i]) pixmap[i] = c.color ? BYTE_ONES : BYTE_ZERO;
      REQ_READ:   if (int'(c.byte_index) < STORE_BYTES) r.read_data = pixmap[c.byte_index];
      default: ;
    endcase
    r.cursor_now = cur_x;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_t want;
    if (!rst_n) begin
      foreach (pixmap[i]) pixmap[i] = BYTE_ZERO;
      cur_x     = '0;
      cur_y     = '0;
      invert_on = 1'b0;
      glyph_ok  = 1'b0;
      rows_full = 1'b0;
      row_n     = 0;
      font_w    = FONT_WIDTH_RST;
      font_h    = FONT_HEIGHT_RST;
      status_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FONT_WIDTH:  font_w = cfg_wdata[4:0];
          CFG_FONT_HEIGHT: font_h = cfg_wdata[5:0];
          default: ;
        endcase
      end
      // Retire the result first: it always belongs to an older command.
      if (out_strobe) begin
        if (status_q.size() == 0) begin
          $error("result beat with no command waiting");
          errs++;
        end else begin
          want = status_q.pop_front();
          if (result.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, result.accepted);
            errs++;
          end
          if (result.read_data !== want.read_data) begin
            $error("read_data: expected 0x%02h, got 0x%02h", want.read_data, result.read_data);
            errs++;
          end
          if (result.cursor_now !== want.cursor_now) begin
            $error("cursor_now: expected %0d, got %0d", want.cursor_now, result.cursor_now);
            errs++;
          end
        end
      end
      if (start && !busy) status_q.push_back(predict_status(cmd));
    end
    outstanding <= status_q.size();
    fail_count  <= errs;
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Glyph writer testbench top
// Drives command and font register beats into the page framebuffer glyph
// writer: a directed pass over pixels, glyphs, cursor, invert, fill and read,
// then random phases at several font sizes built mostly from whole glyphs.
// A checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
  import pfgw_pkg::*;

  // Request codes the block leaves unused; they must still answer.
  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_t                   in_item;
  logic                  out_strobe;
  out_t                  out_item;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    outstanding;
  int                    fail_count;

  int sent;
  bit quiet;
  int font_w;
  int font_h;
  int pen_x;
  int pen_y;

  // Font sizes per random phase; a zero entry picks a random size.
  int phase_w [6] = '{1, 16, 11, 16, 1, 0};
  int phase_h [6] = '{1, 32, 23, 1, 32, 0};

  always #5 clk = ~clk;

  page_framebuffer_glyph_writer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  glyph_writer_checker status_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .cmd         (in_item),
    .out_strobe  (out_strobe),
    .result      (out_item),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  // Most often no gap, often a short one, now and then a long one. A quiet
  // stretch forces back-to-back beats.
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (quiet || p < 45) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Fill every field with random bits, then pin the request code.
  function automatic in_t noise(logic [2:0] req);
    in_t         c;
    logic [63:0] raw;
    raw        = {$urandom, $urandom};
    c          = raw[$bits(in_t)-1:0];
    c.req_type = req;
    return c;
  endfunction

  // Read back a byte, usually one close to where the cursor was last put so
  // that glyph drawing becomes visible.
  function automatic in_t read_near();
    in_t c;
    int  page;
    int  colm;
    c = noise(REQ_READ);
    if ($urandom_range(0, 9) < 6) begin
      page = (pen_y / 8 + $urandom_range(0, 4)) % (SCREEN_HEIGHT_DEF / 8);
      colm = (pen_x + $urandom_range(0, 16)) % SCREEN_WIDTH_DEF;
      c.byte_index = 10'(page * SCREEN_WIDTH_DEF + colm);
    end
    return c;
  endfunction

  // Hold start until the beat is taken, then idle for a random gap. Start is
  // only dropped when a gap follows, so it never toggles within one step.
  task automatic issue(input in_t c);
    int gap;
    start   <= 1'b1;
    in_item <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = idle_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sent++;
  endtask

  // Drop start and wait until every result is back and the block is idle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
  endtask

  task automatic write_font(input int w, input int h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FONT_WIDTH;
    cfg_wdata <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= CFG_FONT_HEIGHT;
    cfg_wdata <= CFG_DATA_W'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
    font_w = w;
    font_h = h;
  endtask

  task automatic random_phase(input int budget);
    in_t  c;
    int   k;
    int   rows;
    int   first_sent;
    logic ink;
    first_sent = sent;
    while (sent - first_sent < budget) begin
      quiet = ($urandom_range(0, 4) == 0);
      k = $urandom_range(0, 99);
      if (k < 50) begin
        // Whole glyph: place the cursor (usually where it fits), then the
        // rows with first and last marks, then peek at the result.
        c = noise(REQ_CURSOR);
        if ($urandom_range(0, 99) < 85) begin
          c.pos_x = 8'($urandom_range(0, SCREEN_WIDTH_DEF - 1 - font_w));
          c.pos_y = 8'($urandom_range(0, SCREEN_HEIGHT_DEF - 1 - font_h));
        end
        pen_x = c.pos_x;
        pen_y = c.pos_y;
        issue(c);
        rows = ($urandom_range(0, 9) < 7) ? font_h : $urandom_range(1, font_h + 3);
        ink  = $urandom_range(0, 1);
        for (int r = 0; r < rows; r++) begin
          c           = noise(REQ_GLYPH);
          c.color     = ink;
          c.first_row = (r == 0);
          c.last_row  = (r == rows - 1);
          issue(c);
        end
        repeat ($urandom_range(0, 3)) issue(read_near());
      end else if (k < 62) begin
        c = noise(REQ_PIXEL);
        if ($urandom_range(0, 4) != 0) begin
          c.pos_x = 8'($urandom_range(0, SCREEN_WIDTH_DEF - 1));
          c.pos_y = 8'($urandom_range(0, SCREEN_HEIGHT_DEF - 1));
        end
        issue(c);
      end else if (k < 77) begin
        issue(read_near());
      end else if (k < 83) begin
        issue(noise(REQ_INVERT));
      end else if (k < 85) begin
        issue(noise(REQ_FILL));
      end else if (k < 88) begin
        issue(noise($urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B));
      end else if (k < 96) begin
        // Stray glyph row with random marks: broken sequences.
        issue(noise(REQ_GLYPH));
      end else begin
        // Cursor anywhere in the 8-bit range, off screen included.
        c = noise(REQ_CURSOR);
        pen_x = c.pos_x;
        pen_y = c.pos_y;
        issue(c);
      end
    end
  endtask

  initial begin : stimulus
    in_t c;
    int  w;
    int  h;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_FONT_WIDTH;
    cfg_wdata <= '0;
    font_w = FONT_WIDTH_RST;
    font_h = FONT_HEIGHT_RST;
    pen_x  = 0;
    pen_y  = 0;
    quiet  = 1'b0;
    sent   = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass at the reset font size (7 x 10). The first beat waits
    // out the clearing pass and must read back zero.
    c = noise(REQ_READ);  c.byte_index = 10'd0;    issue(c);
    c = noise(REQ_PIXEL); c.pos_x = 8'd0;   c.pos_y = 8'd0;  c.color = 1'b1; issue(c);
    c = noise(REQ_PIXEL); c.pos_x = 8'd127; c.pos_y = 8'd63; c.color = 1'b1; issue(c);
    // Off-screen pixels: drop, one past each edge and the far corner.
    c = noise(REQ_PIXEL); c.pos_x = 8'd128; c.pos_y = 8'd5;  c.color = 1'b1; issue(c);
    c = noise(REQ_PIXEL); c.pos_x = 8'd3;   c.pos_y = 8'd64; c.color = 1'b1; issue(c);
    c = noise(REQ_PIXEL); c.pos_x = 8'd255; c.pos_y = 8'd255; c.color = 1'b1; issue(c);
    c = noise(REQ_READ);  c.byte_index = 10'd0;    issue(c);
    c = noise(REQ_READ);  c.byte_index = 10'd1023; issue(c);
    // Inverted white clears the top-left pixel again.
    issue(noise(REQ_INVERT));
    c = noise(REQ_PIXEL); c.pos_x = 8'd0; c.pos_y = 8'd0; c.color = 1'b1; issue(c);
    c = noise(REQ_READ);  c.byte_index = 10'd0; issue(c);
    issue(noise(REQ_INVERT));
    // Three-row glyph at the origin, with the cursor moved mid-glyph.
    c = noise(REQ_CURSOR); c.pos_x = 8'd0; c.pos_y = 8'd0; issue(c);
    c = noise(REQ_GLYPH); c.row_bits = 16'hFFFF; c.color = 1'b1;
    c.first_row = 1'b1; c.last_row = 1'b0; issue(c);
    c = noise(REQ_GLYPH); c.row_bits = 16'hA5A5; c.color = 1'b0;
    c.first_row = 1'b0; c.last_row = 1'b0; issue(c);
    c = noise(REQ_CURSOR); c.pos_x = 8'd40; c.pos_y = 8'd8; issue(c);
    c = noise(REQ_GLYPH); c.row_bits = 16'h0001; c.color = 1'b1;
    c.first_row = 1'b0; c.last_row = 1'b1; issue(c);
    // Row after the glyph closed: rejected.
    c = noise(REQ_GLYPH); c.row_bits = 16'h0000; c.first_row = 1'b0; issue(c);
    // No room to the right, then no room below: the whole glyph is refused.
    c = noise(REQ_CURSOR); c.pos_x = 8'd121; c.pos_y = 8'd0; issue(c);
    c = noise(REQ_GLYPH); c.first_row = 1'b1; c.last_row = 1'b1; issue(c);
    c = noise(REQ_CURSOR); c.pos_x = 8'd0; c.pos_y = 8'd54; issue(c);
    c = noise(REQ_GLYPH); c.first_row = 1'b1; c.last_row = 1'b1; issue(c);
    // Tightest corner that still fits; the cursor then advances to 127.
    c = noise(REQ_CURSOR); c.pos_x = 8'd120; c.pos_y = 8'd53; issue(c);
    c = noise(REQ_GLYPH); c.row_bits = 16'hFFFF; c.first_row = 1'b1; c.last_row = 1'b1;
    issue(c);
    issue(noise(REQ_SPARE_A));
    issue(noise(REQ_SPARE_B));
    // Fill white ignores inversion; read it back, then fill black.
    c = noise(REQ_FILL); c.color = 1'b1; issue(c);
    c = noise(REQ_READ); c.byte_index = 10'd500; issue(c);
    c = noise(REQ_FILL); c.color = 1'b0; issue(c);

    // Random phases: change the font only once the block is idle.
    for (int p = 0; p < 6; p++) begin
      drain();
      w = (phase_w[p] == 0) ? $urandom_range(1, 16) : phase_w[p];
      h = (phase_h[p] == 0) ? $urandom_range(1, MAX_GLYPH_ROWS) : phase_h[p];
      write_font(w, h);
      random_phase(72);
    end

    // Let stray result beats show up before the verdict.
    drain();
    repeat (64) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hang guard: well beyond the slowest legal run.
  initial begin : watchdog
    #50_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/pfgw_pkg.sv
rtl/pfgw_store.sv
rtl/pfgw_pixel_unit.sv
rtl/page_framebuffer_glyph_writer.sv
dv/glyph_writer_checker.sv
dv/tb_top.sv
